>>> hdl/sm83_load_store_unit_defines.svh
// assertion macros for the sm83 load/store unit
`ifndef SM83_LOAD_STORE_UNIT_DEFINES_SVH
`define SM83_LOAD_STORE_UNIT_DEFINES_SVH

// property that must hold whenever reset is released
`define SM83_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SM83_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sm83_pkg.sv
// ----------------------------------------------------------------------------
// sm83_pkg
// shared types and constants of the sm83 load/store unit
// ----------------------------------------------------------------------------
package sm83_pkg;

    localparam int ADDR_W = 16;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_READ = 2'd1,
        CMD_EXEC = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOST,
        ST_FETCH,
        ST_DECODE,
        ST_IMM1,
        ST_IMM2,
        ST_DATA,
        ST_DATA2,
        ST_WB,
        ST_DONE
    } state_t;

    // memory request from the sequencer
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;
    localparam logic [7:0]  FLAG_H    = 8'h20;
    localparam logic [7:0]  FLAG_C    = 8'h10;

endpackage

>>> hdl/sm83_mem.sv
// ----------------------------------------------------------------------------
// sm83_mem
// 64 KiB single-port byte memory with registered read data
// ----------------------------------------------------------------------------
module sm83_mem
    import sm83_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] mem_array [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
                mem_array[req.addr] <= req.wdata;
            rdata <= mem_array[req.addr];
        end
    end

endmodule

>>> hdl/sm83_load_store_unit.sv
// ----------------------------------------------------------------------------
// sm83_load_store_unit
// load/store subset of an sm83 style cpu with a 64 KiB memory
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) carries cmd, host_addr and host_data:
//   load writes a memory byte, read returns one, execute runs one instruction
//   fetched at pc. output channel (out_valid/out_ready) returns one transaction
//   per input: read_byte, cycle_count, unknown_opcode and the register views.
// all state lives in one single-port synchronous memory plus the register
//   file; the sequencer issues at most one memory access per clock.
// host commands go through ST_HOST and ST_DONE; instructions go through
//   ST_FETCH, ST_DECODE, ST_WB and ST_DONE plus one state per further memory
//   access (up to two immediates, up to two data bytes), one command at a time.
// the result sits in an output register; a new command is taken in the same
//   cycle the result is consumed. while the receiver stalls, the result holds
//   and no new command is taken.
// reset restores the cpu register values (pc 0x0100, sp 0xfffe); memory is
//   not cleared and must be loaded by the host before use.
// ----------------------------------------------------------------------------
`include "sm83_load_store_unit_defines.svh"
module sm83_load_store_unit
    import sm83_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] host_addr,
    input  logic [7:0]  host_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_byte,
    output logic [4:0]  cycle_count,
    output logic        unknown_opcode,
    output logic [15:0] af_view,
    output logic [15:0] bc_view,
    output logic [15:0] de_view,
    output logic [15:0] hl_view,
    output logic [15:0] sp_view,
    output logic [15:0] pc_view
);

    state_t      state_reg, state_next;
    cmd_t        cmd_reg;
    logic [7:0]  data_reg;
    logic [7:0]  op_reg, imm1_reg, imm2_reg;
    logic [7:0]  a_reg, f_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [15:0] sp_reg, pc_reg;
    logic        out_valid_reg;
    logic [7:0]  rb_reg;
    logic [4:0]  cyc_reg;
    logic        unk_reg;
    mem_req_t    req;
    logic [7:0]  rdata;
    logic        in_fire;

    // decode
    logic [2:0] dst, src;
    logic is_mov, is_ldi, is_unk, n_imm1, n_imm2, n_data, n_data2, d_write;
    logic [4:0] cyc_val;
    logic [15:0] hl, imm16;
    logic [7:0]  imm1_cur, imm2_cur;

    assign dst   = op_reg[5:3];
    assign src   = op_reg[2:0];
    assign hl    = {h_reg, l_reg};
    // an immediate is usable in the cycle its read data arrives
    assign imm1_cur = (state_reg == ST_IMM1) ? rdata : imm1_reg;
    assign imm2_cur = (state_reg == ST_IMM2) ? rdata : imm2_reg;
    assign imm16 = {imm2_cur, imm1_cur};

    sm83_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

    function automatic logic [7:0] get_r(input logic [2:0] code, input logic [7:0] mval,
            input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
            input logic [7:0] d, input logic [7:0] e, input logic [7:0] h,
            input logic [7:0] l);
        logic [7:0] v;
        begin
            case (code)
                3'd0: v = b;
                3'd1: v = c;
                3'd2: v = d;
                3'd3: v = e;
                3'd4: v = h;
                3'd5: v = l;
                3'd6: v = mval;
                default: v = a;
            endcase
            return v;
        end
    endfunction

    always_comb
    begin
        is_mov  = (op_reg[7:6] == 2'b01) && (op_reg != 8'h76) &&
                  ((src != 3'd7) || (dst == 3'd7));
        is_ldi  = (op_reg[7:6] == 2'b00) && (src == 3'd6);
        is_unk  = 1'b0;
        n_imm1  = 1'b0;
        n_imm2  = 1'b0;
        n_data  = 1'b0;
        n_data2 = 1'b0;
        d_write = 1'b0;
        cyc_val = 5'd0;
        if (is_mov)
        begin
            n_data  = (src == 3'd6) || (dst == 3'd6);
            d_write = (dst == 3'd6);
            cyc_val = n_data ? 5'd8 : 5'd4;
        end
        else if (is_ldi)
        begin
            n_imm1  = 1'b1;
            n_data  = (dst == 3'd6);
            d_write = (dst == 3'd6);
            cyc_val = (dst == 3'd6) ? 5'd12 : 5'd8;
        end
        else
        begin
            unique case (op_reg)
                8'h0A, 8'h1A, 8'hF2, 8'h3A, 8'h2A:
                begin
                    n_data = 1'b1; cyc_val = 5'd8;
                end
                8'hE2, 8'h32, 8'h22:
                begin
                    n_data = 1'b1; d_write = 1'b1; cyc_val = 5'd8;
                end
                8'hFA:
                begin
                    n_imm1 = 1'b1; n_imm2 = 1'b1; n_data = 1'b1; cyc_val = 5'd16;
                end
                8'hE0:
                begin
                    n_imm1 = 1'b1; n_data = 1'b1; d_write = 1'b1; cyc_val = 5'd12;
                end
                8'hF0:
                begin
                    n_imm1 = 1'b1; n_data = 1'b1; cyc_val = 5'd12;
                end
                8'h01, 8'h11, 8'h21, 8'h31:
                begin
                    n_imm1 = 1'b1; n_imm2 = 1'b1; cyc_val = 5'd12;
                end
                8'hF9: cyc_val = 5'd8;
                8'hF8:
                begin
                    n_imm1 = 1'b1; cyc_val = 5'd12;
                end
                8'h08:
                begin
                    n_imm1 = 1'b1; n_imm2 = 1'b1; n_data = 1'b1; n_data2 = 1'b1;
                    d_write = 1'b1; cyc_val = 5'd20;
                end
                8'hF5, 8'hC5, 8'hD5, 8'hE5:
                begin
                    n_data = 1'b1; n_data2 = 1'b1; d_write = 1'b1; cyc_val = 5'd16;
                end
                8'hF1, 8'hC1, 8'hD1, 8'hE1:
                begin
                    n_data = 1'b1; n_data2 = 1'b1; cyc_val = 5'd12;
                end
                default: is_unk = 1'b1;
            endcase
        end
    end

    // data address and write byte for first and second data access
    logic [15:0] daddr, daddr2;
    logic [7:0]  dwdata, dwdata2;
    logic [7:0]  pair_hi, pair_lo;

    always_comb
    begin
        case (op_reg[5:4])
            2'd0:    begin pair_hi = b_reg; pair_lo = c_reg; end
            2'd1:    begin pair_hi = d_reg; pair_lo = e_reg; end
            2'd2:    begin pair_hi = h_reg; pair_lo = l_reg; end
            default: begin pair_hi = a_reg; pair_lo = f_reg; end
        endcase
        daddr   = hl;
        daddr2  = imm16 + 16'd1;
        dwdata  = a_reg;
        dwdata2 = sp_reg[15:8];
        if (is_mov)
            dwdata = get_r(src, 8'h00, a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg);
        else if (is_ldi)
            dwdata = imm1_cur;
        else
        begin
            case (op_reg)
                8'h0A: daddr = {b_reg, c_reg};
                8'h1A: daddr = {d_reg, e_reg};
                8'hFA: daddr = imm16;
                8'hF2, 8'hE2: daddr = HIGH_PAGE | {8'h00, c_reg};
                8'hE0, 8'hF0: daddr = HIGH_PAGE | {8'h00, imm1_cur};
                8'h08:
                begin
                    daddr = imm16; dwdata = sp_reg[7:0];
                end
                8'hF5, 8'hC5, 8'hD5, 8'hE5:
                begin
                    daddr = sp_reg - 16'd1; dwdata = pair_hi;
                    daddr2 = sp_reg - 16'd2; dwdata2 = pair_lo;
                end
                8'hF1, 8'hC1, 8'hD1, 8'hE1:
                begin
                    daddr = sp_reg; daddr2 = sp_reg + 16'd1;
                end
                default: ;
            endcase
        end
    end

    // ready only when idle and no result is pending or the pending one is consumed now
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = (cmd_t'(cmd) == CMD_EXEC) ? ST_FETCH : ST_HOST;
            ST_HOST:   state_next = ST_DONE;
            ST_FETCH:  state_next = ST_DECODE;
            ST_DECODE: state_next = n_imm1 ? ST_IMM1 : (n_data ? ST_DATA : ST_WB);
            ST_IMM1:   state_next = n_imm2 ? ST_IMM2 : (n_data ? ST_DATA : ST_WB);
            ST_IMM2:   state_next = n_data ? ST_DATA : ST_WB;
            ST_DATA:   state_next = n_data2 ? ST_DATA2 : ST_WB;
            ST_DATA2:  state_next = ST_WB;
            ST_WB:     state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // memory request per state
    always_comb
    begin
        req = '0;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    req.en    = (cmd_t'(cmd) != CMD_NOP);
                    req.we    = (cmd_t'(cmd) == CMD_LOAD);
                    req.addr  = (cmd_t'(cmd) == CMD_EXEC) ? pc_reg : host_addr;
                    req.wdata = host_data;
                end
            ST_DECODE, ST_IMM1:
                if (n_imm1 && (state_reg == ST_DECODE || n_imm2))
                begin
                    req.en   = 1'b1;
                    req.addr = pc_reg;
                end
                else if (n_data)
                begin
                    req.en = 1'b1; req.we = d_write;
                    req.addr = daddr; req.wdata = dwdata;
                end
            ST_IMM2:
                if (n_data)
                begin
                    req.en = 1'b1; req.we = d_write;
                    req.addr = daddr; req.wdata = dwdata;
                end
            ST_DATA:
                if (n_data2)
                begin
                    req.en = 1'b1; req.we = d_write;
                    req.addr = daddr2; req.wdata = dwdata2;
                end
            default: ;
        endcase
    end

    logic [15:0] sext, ldhl_sum;
    logic [4:0]  hsum;
    logic [8:0]  csum;
    assign sext     = {{8{imm1_reg[7]}}, imm1_reg};
    assign ldhl_sum = sp_reg + sext;
    assign hsum     = {1'b0, sp_reg[3:0]} + {1'b0, imm1_reg[3:0]};
    assign csum     = {1'b0, sp_reg[7:0]} + {1'b0, imm1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cmd_reg  <= CMD_LOAD;
            data_reg <= 8'h00;
            op_reg   <= 8'h00;
            imm1_reg <= 8'h00;
            imm2_reg <= 8'h00;
            a_reg <= 8'h00; f_reg <= 8'hB0;
            b_reg <= 8'h00; c_reg <= 8'h13;
            d_reg <= 8'h00; e_reg <= 8'hD8;
            h_reg <= 8'h01; l_reg <= 8'h4D;
            sp_reg <= 16'hFFFE;
            pc_reg <= 16'h0100;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_fire)
                    begin
                        cmd_reg  <= cmd_t'(cmd);
                        data_reg <= host_data;
                        if (cmd_t'(cmd) == CMD_EXEC)
                            pc_reg <= pc_reg + 16'd1;
                    end
                ST_FETCH: op_reg <= rdata;
                ST_DECODE:
                    if (n_imm1)
                        pc_reg <= pc_reg + 16'd1;
                ST_IMM1:
                begin
                    imm1_reg <= rdata;
                    if (n_imm2)
                        pc_reg <= pc_reg + 16'd1;
                end
                ST_IMM2: imm2_reg <= rdata;
                ST_DATA: data_reg <= rdata;
                ST_DATA2: ;
                ST_WB:
                begin
                    if (is_mov)
                    begin
                        case (dst)
                            3'd0: b_reg <= get_r(src, data_reg, a_reg, b_reg, c_reg,
                                                 d_reg, e_reg, h_reg, l_reg);
                            3'd1: c_reg <= get_r(src, data_reg, a_reg, b_reg, c_reg,
                                                 d_reg, e_reg, h_reg, l_reg);
                            3'd2: d_reg <= get_r(src, data_reg, a_reg, b_reg, c_reg,
                                                 d_reg, e_reg, h_reg, l_reg);
                            3'd3: e_reg <= get_r(src, data_reg, a_reg, b_reg, c_reg,
                                                 d_reg, e_reg, h_reg, l_reg);
                            3'd4: h_reg <= get_r(src, data_reg, a_reg, b_reg, c_reg,
                                                 d_reg, e_reg, h_reg, l_reg);
                            3'd5: l_reg <= get_r(src, data_reg, a_reg, b_reg, c_reg,
                                                 d_reg, e_reg, h_reg, l_reg);
                            3'd7: a_reg <= get_r(src, data_reg, a_reg, b_reg, c_reg,
                                                 d_reg, e_reg, h_reg, l_reg);
                            default: ;
                        endcase
                    end
                    else if (is_ldi)
                    begin
                        case (dst)
                            3'd0: b_reg <= imm1_reg;
                            3'd1: c_reg <= imm1_reg;
                            3'd2: d_reg <= imm1_reg;
                            3'd3: e_reg <= imm1_reg;
                            3'd4: h_reg <= imm1_reg;
                            3'd5: l_reg <= imm1_reg;
                            3'd7: a_reg <= imm1_reg;
                            default: ;
                        endcase
                    end
                    else
                    begin
                        case (op_reg)
                            8'h0A, 8'h1A, 8'hFA, 8'hF2, 8'hF0: a_reg <= data_reg;
                            8'h3A:
                            begin
                                a_reg <= data_reg; {h_reg, l_reg} <= hl - 16'd1;
                            end
                            8'h2A:
                            begin
                                a_reg <= data_reg; {h_reg, l_reg} <= hl + 16'd1;
                            end
                            8'h32: {h_reg, l_reg} <= hl - 16'd1;
                            8'h22: {h_reg, l_reg} <= hl + 16'd1;
                            8'h01: {b_reg, c_reg} <= imm16;
                            8'h11: {d_reg, e_reg} <= imm16;
                            8'h21: {h_reg, l_reg} <= imm16;
                            8'h31: sp_reg <= imm16;
                            8'hF9: sp_reg <= hl;
                            8'hF8:
                            begin
                                {h_reg, l_reg} <= ldhl_sum;
                                f_reg <= (hsum[4] ? FLAG_H : 8'h00) |
                                         (csum[8] ? FLAG_C : 8'h00);
                            end
                            8'hF5, 8'hC5, 8'hD5, 8'hE5: sp_reg <= sp_reg - 16'd2;
                            // second popped byte is still held on rdata, first is in data_reg
                            8'hF1:
                            begin
                                f_reg <= {data_reg[7:4], 4'h0}; a_reg <= rdata;
                                sp_reg <= sp_reg + 16'd2;
                            end
                            8'hC1:
                            begin
                                c_reg <= data_reg; b_reg <= rdata; sp_reg <= sp_reg + 16'd2;
                            end
                            8'hD1:
                            begin
                                e_reg <= data_reg; d_reg <= rdata; sp_reg <= sp_reg + 16'd2;
                            end
                            8'hE1:
                            begin
                                l_reg <= data_reg; h_reg <= rdata; sp_reg <= sp_reg + 16'd2;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DONE: ;
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_HOST)
        begin
            rb_reg  <= (cmd_reg == CMD_READ) ? rdata : 8'h00;
            cyc_reg <= 5'd0;
            unk_reg <= 1'b0;
        end
        else if (state_reg == ST_WB)
        begin
            rb_reg  <= 8'h00;
            cyc_reg <= cyc_val;
            unk_reg <= is_unk;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_byte      = rb_reg;
    assign cycle_count    = cyc_reg;
    assign unknown_opcode = unk_reg;
    assign af_view        = {a_reg, f_reg};
    assign bc_view        = {b_reg, c_reg};
    assign de_view        = {d_reg, e_reg};
    assign hl_view        = {h_reg, l_reg};
    assign sp_view        = sp_reg;
    assign pc_view        = pc_reg;

    `SM83_ASSERT(a_ready_idle, (in_ready |-> state_reg == ST_IDLE), "ready outside idle")
    `SM83_ASSERT_NEXT(a_wb_done, state_reg == ST_WB, state_reg == ST_DONE, "wb not followed by done")
    `SM83_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "accepted twice in a row")
    `SM83_ASSERT(a_unk_zero_cyc, (out_valid |-> !(unknown_opcode && cycle_count != 5'd0)),
        "unknown opcode with nonzero cycle count")

endmodule
